@@ rtl/core/sc1h_pkg.sv @@
// sc1h_pkg: shared types, constants and lookup tables for the set 1 to HID translator
// no dependencies; imported by every module of the translator
package sc1h_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  localparam logic [7:0] CodePause   = 8'h45;
  localparam logic [7:0] CodeLshift  = 8'h2A;
  localparam logic [7:0] UsageLshift = 8'hE1;
  localparam logic [7:0] UsagePause  = 8'h48;

  // operation codes carried in tuser
  localparam logic OpKey   = 1'b0;
  localparam logic OpFlush = 1'b1;

  // work handed from front to back: one or two update records
  typedef struct packed {
    logic       two;
    logic [7:0] usage0;
    logic       pressed0;
    logic [7:0] usage1;
    logic       pressed1;
  } cmd_t;

  // plain set 1 codes
  function automatic logic [7:0] rom_plain(input logic [7:0] code);
    logic [7:0] u;
    u = 8'h00;
    case (code)
      8'h01: u = 8'h29; 8'h02: u = 8'h1E; 8'h03: u = 8'h1F; 8'h04: u = 8'h20;
      8'h05: u = 8'h21; 8'h06: u = 8'h22; 8'h07: u = 8'h23; 8'h08: u = 8'h24;
      8'h09: u = 8'h25; 8'h0A: u = 8'h26; 8'h0B: u = 8'h27; 8'h0C: u = 8'h2D;
      8'h0D: u = 8'h2E; 8'h0E: u = 8'h2A; 8'h0F: u = 8'h2B; 8'h10: u = 8'h14;
      8'h11: u = 8'h1A; 8'h12: u = 8'h08; 8'h13: u = 8'h15; 8'h14: u = 8'h17;
      8'h15: u = 8'h1C; 8'h16: u = 8'h18; 8'h17: u = 8'h0C; 8'h18: u = 8'h12;
      8'h19: u = 8'h13; 8'h1A: u = 8'h2F; 8'h1B: u = 8'h30; 8'h1C: u = 8'h28;
      8'h1D: u = 8'hE0; 8'h1E: u = 8'h04; 8'h1F: u = 8'h16; 8'h20: u = 8'h07;
      8'h21: u = 8'h09; 8'h22: u = 8'h0A; 8'h23: u = 8'h0B; 8'h24: u = 8'h0D;
      8'h25: u = 8'h0E; 8'h26: u = 8'h0F; 8'h27: u = 8'h33; 8'h28: u = 8'h34;
      8'h29: u = 8'h35; 8'h2A: u = 8'hE1; 8'h2B: u = 8'h31; 8'h2C: u = 8'h1D;
      8'h2D: u = 8'h1B; 8'h2E: u = 8'h06; 8'h2F: u = 8'h19; 8'h30: u = 8'h05;
      8'h31: u = 8'h11; 8'h32: u = 8'h10; 8'h33: u = 8'h36; 8'h34: u = 8'h37;
      8'h35: u = 8'h38; 8'h36: u = 8'hE5; 8'h37: u = 8'h55; 8'h38: u = 8'hE2;
      8'h39: u = 8'h2C; 8'h3A: u = 8'h39; 8'h3B: u = 8'h3A; 8'h3C: u = 8'h3B;
      8'h3D: u = 8'h3C; 8'h3E: u = 8'h3D; 8'h3F: u = 8'h3E; 8'h40: u = 8'h3F;
      8'h41: u = 8'h40; 8'h42: u = 8'h41; 8'h43: u = 8'h42; 8'h44: u = 8'h43;
      8'h45: u = 8'h53; 8'h46: u = 8'h47; 8'h47: u = 8'h5F; 8'h48: u = 8'h60;
      8'h49: u = 8'h61; 8'h4A: u = 8'h56; 8'h4B: u = 8'h5C; 8'h4C: u = 8'h5D;
      8'h4D: u = 8'h5E; 8'h4E: u = 8'h57; 8'h4F: u = 8'h59; 8'h50: u = 8'h5A;
      8'h51: u = 8'h5B; 8'h52: u = 8'h62; 8'h53: u = 8'h63; 8'h56: u = 8'h64;
      8'h57: u = 8'h44; 8'h58: u = 8'h45;
      default: u = 8'h00;
    endcase
    return u;
  endfunction

  // codes that followed an E0 prefix
  function automatic logic [7:0] rom_ext(input logic [7:0] code);
    logic [7:0] u;
    u = 8'h00;
    case (code)
      8'h1C: u = 8'h58; 8'h1D: u = 8'hE4; 8'h35: u = 8'h54; 8'h37: u = 8'h46;
      8'h38: u = 8'hE6; 8'h47: u = 8'h4A; 8'h48: u = 8'h52; 8'h49: u = 8'h4B;
      8'h4B: u = 8'h50; 8'h4D: u = 8'h4F; 8'h4F: u = 8'h4D; 8'h50: u = 8'h51;
      8'h51: u = 8'h4E; 8'h52: u = 8'h49; 8'h53: u = 8'h4C; 8'h5B: u = 8'hE3;
      8'h5C: u = 8'hE7; 8'h5D: u = 8'h65;
      default: u = 8'h00;
    endcase
    return u;
  endfunction

endpackage

@@ rtl/core/sc1h_front.sv @@
// sc1h_front: accepts events, tracks the pending left shift, builds update records
// depends on sc1h_pkg; feeds sc1h_queue
module sc1h_front
  import sc1h_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [7:0]  scancode,
  input  logic        e0_prefix,
  input  logic        e1_prefix,
  input  logic        release_req,
  input  logic        real_lshift_held,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic shift_pending_level;
  logic shift_pending_valid;
  logic level_next;
  logic valid_next;
  logic accept;
  logic down;
  logic ra_v;
  logic [7:0] ra_u;
  logic ra_p;
  logic rb_v;
  logic [7:0] rb_u;
  logic rb_p;
  logic [7:0] rom_u;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign down     = !release_req;

  // classify the word into at most two records
  always_comb begin
    level_next = shift_pending_level;
    valid_next = shift_pending_valid;
    ra_v = 1'b0;
    ra_u = UsageLshift;
    ra_p = shift_pending_level;
    rb_v = 1'b0;
    rb_u = 8'h00;
    rb_p = down;
    rom_u = e0_prefix ? rom_ext(scancode) : rom_plain(scancode);
    if (operation == OpFlush) begin
      ra_v = shift_pending_valid;
      valid_next = 1'b0;
    end else if (e1_prefix && scancode == CodePause) begin
      rb_v = 1'b1;
      rb_u = UsagePause;
    end else if (scancode == CodeLshift && !e0_prefix) begin
      ra_v = shift_pending_valid;
      level_next = down;
      valid_next = 1'b1;
    end else begin
      if (e0_prefix) begin
        ra_v = shift_pending_valid && real_lshift_held;
        ra_p = 1'b1;
      end else begin
        ra_v = shift_pending_valid;
      end
      valid_next = 1'b0;
      rb_v = (rom_u != 8'h00);
      rb_u = rom_u;
    end
  end

  // pack records, first one in slot 0
  always_comb begin
    q_push = accept && (ra_v || rb_v);
    if (ra_v) begin
      q_cmd.two      = rb_v;
      q_cmd.usage0   = ra_u;
      q_cmd.pressed0 = ra_p;
    end else begin
      q_cmd.two      = 1'b0;
      q_cmd.usage0   = rb_u;
      q_cmd.pressed0 = rb_p;
    end
    q_cmd.usage1   = rb_u;
    q_cmd.pressed1 = rb_p;
  end

  // pending shift state
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_pending_level <= 1'b0;
      shift_pending_valid <= 1'b0;
    end else if (accept) begin
      shift_pending_level <= level_next;
      shift_pending_valid <= valid_next;
    end
  end

endmodule

@@ rtl/core/sc1h_queue.sv @@
// sc1h_queue: short fifo of record pairs between front and back
// depends on sc1h_pkg
module sc1h_queue
  import sc1h_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t entries [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QPtrW:0]   count;
  logic do_push;
  logic do_pop;

  assign full    = (count == (QPtrW+1)'(QDepth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/sc1h_back.sv @@
// sc1h_back: drains record pairs, one record per cycle unless the output stalls, into the output register
// depends on sc1h_pkg; fed by sc1h_queue
module sc1h_back
  import sc1h_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  cmd_t       q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] usage,
  output logic       pressed,
  output logic       last
);

  logic phase;
  logic load;

  assign load  = !q_empty && (!out_valid || out_ready);
  assign q_pop = load && (phase || !q_head.two);

  // output register and record phase
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= !q_pop;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      usage   <= phase ? q_head.usage1 : q_head.usage0;
      pressed <= phase ? q_head.pressed1 : q_head.pressed0;
      last    <= phase || !q_head.two;
    end
  end

endmodule

@@ rtl/core/scancode_set1_to_hid_translator.sv @@
// scancode_set1_to_hid_translator: set 1 scancode events in, HID key updates out
// depends on sc1h_pkg, sc1h_front, sc1h_queue, sc1h_back
// path: an accepted event word is stored in the queue, then its records are loaded into the output register
// throughput: one event word per cycle in unless the queue is full, one record per cycle
//   out unless stalled; two-record events go out in turn, a 4-entry queue absorbs bursts
// reset: synchronous rst clears the pending shift, queue and output valid
module scancode_set1_to_hid_translator
  import sc1h_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // scancode[7:0], e0_prefix, e1_prefix, release_req,
                                // real_lshift_held, zero pad[15:12]
  input  logic        s_tuser,  // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // usage[7:0], pressed, zero pad[15:9]
  output logic        m_tlast   // last
);

  logic q_push;
  cmd_t q_cmd;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_head;
  logic [7:0] usage;
  logic pressed;

  sc1h_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .operation        (s_tuser),
    .scancode         (s_tdata[7:0]),
    .e0_prefix        (s_tdata[8]),
    .e1_prefix        (s_tdata[9]),
    .release_req      (s_tdata[10]),
    .real_lshift_held (s_tdata[11]),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (q_cmd)
  );

  sc1h_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  sc1h_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .usage     (usage),
    .pressed   (pressed),
    .last      (m_tlast)
  );

  assign m_tdata = {7'b0, pressed, usage};

endmodule

@@ rtl/core/sc1h_checker.sv @@
// sc1h_checker: port-level assertions for the translator, bound to the top level
// depends on sc1h_pkg and scancode_set1_to_hid_translator
module sc1h_checker
  import sc1h_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);

  // stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // unmapped codes never produce a record
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:0] != 8'h00)
    else $error("record with zero usage");

  // a leading record is always the left shift commit
  a_lead: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[7:0] == UsageLshift)
    else $error("non-final record is not left shift");

endmodule

bind scancode_set1_to_hid_translator sc1h_checker u_sc1h_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
